// ----- rtl/mnpm_pkg.sv -----
// shared types and constants of the mutual nearest point matcher
`timescale 1ns / 1ps
package mnpm_pkg;

  localparam logic [2:0] ACT_LOAD_MODEL  = 3'd0;
  localparam logic [2:0] ACT_LOAD_SCENE  = 3'd1;
  localparam logic [2:0] ACT_QUERY_MODEL = 3'd2;
  localparam logic [2:0] ACT_QUERY_SCENE = 3'd3;
  localparam logic [2:0] ACT_CLEAR       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_MAX_RT   = 2'd0;
  localparam logic [1:0] REG_MZ_SCALE = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  localparam int unsigned DIST_W = 73;
  localparam int unsigned NEED_W = 89;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] retention_time;
    logic [31:0] mass_to_charge;
    logic [7:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       matched;
    logic [7:0] partner_index;
  } out_item_t;

endpackage

// ----- rtl/mnpm_if.sv -----
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface mnpm_in_if;
  logic               valid;
  logic               ready;
  mnpm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mnpm_out_if;
  logic                valid;
  logic                ready;
  mnpm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mutual_nearest_point_matcher.sv -----
// top level of the mutual nearest point matcher
//
// channel   dir  handshake    payload
// in_i      in   valid/ready  action, retention_time, mass_to_charge, entry_index
// out_o     out  valid/ready  status, matched, partner_index
// cfg       in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// loads, clears and rejected queries answer in the cycle after they are accepted
// a query runs two scans through one read port per point memory and a five stage
// distance pipeline
// reset clears counts and loads config defaults; point memories are not cleared
// a result waiting on out_o holds off the next item
`timescale 1ns / 1ps
module mutual_nearest_point_matcher #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mnpm_in_if.sink     in_i,
  mnpm_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);
  localparam int unsigned DW = mnpm_pkg::DIST_W;
  localparam int unsigned NW = mnpm_pkg::NEED_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FP   = 4'd1;
  localparam logic [3:0] S_WP   = 4'd2;
  localparam logic [3:0] S_S1   = 4'd3;
  localparam logic [3:0] S_FQ   = 4'd4;
  localparam logic [3:0] S_WQ   = 4'd5;
  localparam logic [3:0] S_S2   = 4'd6;
  localparam logic [3:0] S_C1   = 4'd7;
  localparam logic [3:0] S_C2   = 4'd8;
  localparam logic [3:0] S_C3   = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;

  logic [55:0] model_mem [MAX_POINTS];
  logic [55:0] scene_mem [MAX_POINTS];
  logic [55:0] model_rd_q, scene_rd_q;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] model_cnt_q, scene_cnt_q;
  logic [23:0]   max_rt_q;
  logic [31:0]   mz_scale_q;
  logic [15:0]   gap_q;

  logic          out_v_q;
  mnpm_pkg::out_item_t out_q, res_q;

  logic          qsel_q;
  logic [AW-1:0] idx_q;
  logic [CW-1:0] iss_q;
  logic [23:0]   rx_q;
  logic [35:0]   ry_q;

  logic          rd_en;
  logic          rd_mem;
  logic [AW-1:0] rd_addr;

  logic          p0_v_q, p0_s_q, p0_m_q;
  logic [AW-1:0] p0_i_q;
  logic          p1_v_q, p1_s_q;
  logic [AW-1:0] p1_i_q;
  logic [23:0]   p1_x_q;
  logic [35:0]   p1_y_q;
  logic          p2_v_q;
  logic [AW-1:0] p2_i_q;
  logic [23:0]   p2_dx_q;
  logic [35:0]   p2_dy_q;
  logic          p3_v_q;
  logic [AW-1:0] p3_i_q;
  logic [47:0]   p3_xx_q;
  logic [35:0]   p3_hh_q, p3_hl_q, p3_ll_q;
  logic          p4_v_q;
  logic [AW-1:0] p4_i_q;
  logic [DW-1:0] p4_d_q;

  logic          b_h1_q, b_h2_q;
  logic [AW-1:0] b_i1_q;
  logic [DW-1:0] b_d1_q, b_d2_q;
  logic          f_h2_q;
  logic [AW-1:0] f_i1_q;
  logic [DW-1:0] f_d1_q, f_d2_q;

  logic [52:0]   need_lo_q;
  logic [51:0]   need_hi_q;
  logic [47:0]   lim_q;
  logic [NW-1:0] need_q;
  logic          lim_ok_q;

  logic          accept;
  logic          slot_free;
  logic          pipe_busy;
  logic [CW-1:0] own_n, oth_n;
  logic [55:0]   p0_data;
  logic [63:0]   y_prod;
  logic [35:0]   dy_abs;
  logic [23:0]   dx_abs;
  logic          begin_scan;

  assign slot_free  = !out_v_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept     = in_i.valid && in_i.ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  assign own_n = qsel_q ? scene_cnt_q : model_cnt_q;
  assign oth_n = qsel_q ? model_cnt_q : scene_cnt_q;
  assign pipe_busy = p0_v_q || p1_v_q || p2_v_q || p3_v_q || p4_v_q;

  // memory read control
  always_comb begin
    rd_en   = 1'b0;
    rd_mem  = qsel_q;
    rd_addr = idx_q;
    case (state_q)
      S_FP: begin
        rd_en = 1'b1;
      end
      S_S1: begin
        rd_en   = iss_q < oth_n;
        rd_mem  = !qsel_q;
        rd_addr = iss_q[AW-1:0];
      end
      S_FQ: begin
        rd_en   = 1'b1;
        rd_mem  = !qsel_q;
        rd_addr = f_i1_q;
      end
      S_S2: begin
        rd_en   = iss_q < own_n;
        rd_addr = iss_q[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.data.action == mnpm_pkg::ACT_LOAD_MODEL && model_cnt_q < FULL) begin
      model_mem[model_cnt_q[AW-1:0]] <= {in_i.data.retention_time, in_i.data.mass_to_charge};
    end
    if (rd_en) begin
      model_rd_q <= model_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.data.action == mnpm_pkg::ACT_LOAD_SCENE && scene_cnt_q < FULL) begin
      scene_mem[scene_cnt_q[AW-1:0]] <= {in_i.data.retention_time, in_i.data.mass_to_charge};
    end
    if (rd_en) begin
      scene_rd_q <= scene_mem[rd_addr];
    end
  end

  // distance pipeline
  assign p0_data = p0_m_q ? scene_rd_q : model_rd_q;
  assign y_prod  = 64'(p0_data[31:0]) * 64'(mz_scale_q);
  assign dx_abs  = (p1_x_q > rx_q) ? p1_x_q - rx_q : rx_q - p1_x_q;
  assign dy_abs  = (p1_y_q > ry_q) ? p1_y_q - ry_q : ry_q - p1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else begin
      p0_v_q <= rd_en;
      p1_v_q <= p0_v_q;
      p2_v_q <= p1_v_q && p1_s_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_s_q  <= (state_q == S_S1) || (state_q == S_S2);
    p0_m_q  <= rd_mem;
    p0_i_q  <= rd_addr;
    p1_s_q  <= p0_s_q;
    p1_i_q  <= p0_i_q;
    p1_x_q  <= p0_data[55:32];
    p1_y_q  <= y_prod[63:28];
    p2_i_q  <= p1_i_q;
    p2_dx_q <= dx_abs;
    p2_dy_q <= dy_abs;
    p3_i_q  <= p2_i_q;
    p3_xx_q <= 48'(p2_dx_q) * 48'(p2_dx_q);
    p3_hh_q <= 36'(p2_dy_q[35:18]) * 36'(p2_dy_q[35:18]);
    p3_hl_q <= 36'(p2_dy_q[35:18]) * 36'(p2_dy_q[17:0]);
    p3_ll_q <= 36'(p2_dy_q[17:0]) * 36'(p2_dy_q[17:0]);
    p4_i_q  <= p3_i_q;
    p4_d_q  <= (DW'(p3_hh_q) << 36) + (DW'(p3_hl_q) << 19) + DW'(p3_ll_q) + DW'(p3_xx_q);
  end

  assign begin_scan = ((state_q == S_WP) || (state_q == S_WQ)) && p1_v_q;

  // nearest and second nearest tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_h1_q <= 1'b0;
      b_h2_q <= 1'b0;
    end else if (begin_scan) begin
      b_h1_q <= 1'b0;
      b_h2_q <= 1'b0;
    end else if (p4_v_q) begin
      if (!b_h1_q || p4_d_q < b_d1_q) begin
        b_h2_q <= b_h1_q;
        b_h1_q <= 1'b1;
      end else if (!b_h2_q || p4_d_q < b_d2_q) begin
        b_h2_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p4_v_q) begin
      if (!b_h1_q || p4_d_q < b_d1_q) begin
        b_d2_q <= b_d1_q;
        b_d1_q <= p4_d_q;
        b_i1_q <= p4_i_q;
      end else if (!b_h2_q || p4_d_q < b_d2_q) begin
        b_d2_q <= p4_d_q;
      end
    end
    if (begin_scan) begin
      rx_q <= p1_x_q;
      ry_q <= p1_y_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_i.data.action == mnpm_pkg::ACT_QUERY_MODEL ||
                       in_i.data.action == mnpm_pkg::ACT_QUERY_SCENE)) begin
          if (IW'(in_i.data.entry_index) < IW'(in_i.data.action[0] ? scene_cnt_q
                                                                    : model_cnt_q)) begin
            state_d = S_FP;
          end
        end
      end
      S_FP: state_d = S_WP;
      S_WP: if (p1_v_q) state_d = S_S1;
      S_S1: begin
        if (!(iss_q < oth_n) && !pipe_busy) state_d = b_h1_q ? S_FQ : S_RESP;
      end
      S_FQ: state_d = S_WQ;
      S_WQ: if (p1_v_q) state_d = S_S2;
      S_S2: if (!(iss_q < own_n) && !pipe_busy) state_d = S_C1;
      S_C1: state_d = S_C2;
      S_C2: state_d = S_C3;
      S_C3: state_d = S_RESP;
      S_RESP: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      model_cnt_q <= '0;
      scene_cnt_q <= '0;
      max_rt_q    <= 24'd320;
      mz_scale_q  <= 32'd1310720;
      gap_q       <= 16'd0;
      out_v_q     <= 1'b0;
      iss_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mnpm_pkg::REG_MAX_RT:   max_rt_q   <= cfg_data_i[23:0];
          mnpm_pkg::REG_MZ_SCALE: mz_scale_q <= cfg_data_i;
          mnpm_pkg::REG_GAP:      gap_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // immediate answers and finished queries fill the result register
      if ((accept && state_d == S_IDLE) || (state_q == S_RESP && slot_free)) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (accept) begin
        case (in_i.data.action)
          mnpm_pkg::ACT_LOAD_MODEL: begin
            if (model_cnt_q < FULL) model_cnt_q <= model_cnt_q + 1'b1;
          end
          mnpm_pkg::ACT_LOAD_SCENE: begin
            if (scene_cnt_q < FULL) scene_cnt_q <= scene_cnt_q + 1'b1;
          end
          mnpm_pkg::ACT_CLEAR: begin
            model_cnt_q <= '0;
            scene_cnt_q <= '0;
          end
          default: ;
        endcase
      end
      if (begin_scan) begin
        iss_q <= '0;
      end else if (rd_en && (state_q == S_S1 || state_q == S_S2)) begin
        iss_q <= iss_q + 1'b1;
      end
    end
  end

  // query bookkeeping, checks and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qsel_q <= in_i.data.action[0];
      idx_q  <= AW'(in_i.data.entry_index);
      out_q.matched       <= 1'b0;
      out_q.partner_index <= '0;
      if ((in_i.data.action == mnpm_pkg::ACT_LOAD_MODEL && !(model_cnt_q < FULL)) ||
          (in_i.data.action == mnpm_pkg::ACT_LOAD_SCENE && !(scene_cnt_q < FULL))) begin
        out_q.status <= mnpm_pkg::ST_FULL;
      end else if ((in_i.data.action == mnpm_pkg::ACT_QUERY_MODEL ||
                    in_i.data.action == mnpm_pkg::ACT_QUERY_SCENE) && state_d == S_IDLE) begin
        out_q.status <= mnpm_pkg::ST_RANGE;
      end else begin
        out_q.status <= mnpm_pkg::ST_OK;
      end
      res_q <= '0;
    end
    if (state_q == S_S1 && state_d != S_S1) begin
      f_i1_q <= b_i1_q;
      f_d1_q <= b_d1_q;
      f_d2_q <= b_d2_q;
      f_h2_q <= b_h2_q;
    end
    if (state_q == S_C1) begin
      need_lo_q <= 53'(f_d1_q[36:0]) * 53'(gap_q);
      need_hi_q <= 52'(f_d1_q[DW-1:37]) * 52'(gap_q);
      lim_q     <= 48'(max_rt_q) * 48'(max_rt_q);
    end
    if (state_q == S_C2) begin
      need_q   <= (NW'(need_hi_q) << 37) + NW'(need_lo_q);
      lim_ok_q <= f_d1_q <= DW'(lim_q);
    end
    if (state_q == S_C3) begin
      if (b_i1_q == idx_q && lim_ok_q &&
          (!f_h2_q || (NW'(f_d2_q) << 8) >= need_q) &&
          (!b_h2_q || (NW'(b_d2_q) << 8) >= need_q)) begin
        res_q.matched       <= 1'b1;
        res_q.partner_index <= 8'(f_i1_q);
      end
    end
    if (state_q == S_RESP && slot_free) begin
      out_q <= res_q;
    end
  end

endmodule
